@@ sv/lep_pkg.sv @@
// ----------------------------------------------------------------------------
// lep_pkg
// Shared constants, types and the log2 lookup table for the Lyapunov pixel unit.
// ----------------------------------------------------------------------------
package lep_pkg;

  // log2 table resolution (table holds 2^LOG_TABLE_BITS+1 entries)
  localparam int LOG_TABLE_BITS = 8;
  localparam int TAB_SIZE       = (1 << LOG_TABLE_BITS) + 1;
  localparam int TAB_IDX_W      = LOG_TABLE_BITS + 1;
  localparam int TAB_W          = 27;
  localparam int REM_W          = 16;

  // shared multiplier width
  localparam int MUL_W  = 36;
  localparam int PROD_W = 2 * MUL_W;

  // fixed-point constants
  localparam logic signed [MUL_W-1:0] ONE_Q30 = MUL_W'(64'd1 << 30);
  localparam logic [29:0]             LN2_Q30 = 30'd744261118;

  // register map
  localparam logic [7:0] REG_ROUND_COUNT = 8'd0;
  localparam logic [7:0] REG_COLOR_SCALE = 8'd1;

  localparam logic [7:0]  ROUND_COUNT_RST = 8'd10;
  localparam logic [31:0] COLOR_SCALE_RST = 32'd65536;

  typedef logic [TAB_W-1:0] log_tab_t [TAB_SIZE];

  // log2(1 + i/2^LOG_TABLE_BITS) in Q.26 by repeated squaring of a Q30 mantissa
  function automatic log_tab_t build_log_tab();
    log_tab_t          tab;
    longint unsigned   v;
    logic [TAB_W-1:0]  res;
    for (int i = 0; i < TAB_SIZE; i++) begin
      v   = (longint'(1 << LOG_TABLE_BITS) + longint'(i)) << (30 - LOG_TABLE_BITS);
      res = '0;
      if (v >= (64'd1 << 31)) begin
        res = TAB_W'(64'd1 << 26);
      end else begin
        for (int j = 1; j <= 26; j++) begin
          v = (v * v) >> 30;
          if (v >= (64'd1 << 31)) begin
            res = res | TAB_W'(64'd1 << (26 - j));
            v   = v >> 1;
          end
        end
      end
      tab[i] = res;
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

@@ sv/lyapunov_exponent_pixel_unit.sv @@
// Each map step runs the shared multiplier sequence; a step with zero derivative
// skips the normalise, table and log states. After the last step the bit-serial
// divider averages the sum and the color product is formed. A new pixel is
// accepted only after the previous color has been loaded into the output register.
// in_ready is low while busy. Reset: synchronous active-low rst_n returns to idle
// and loads round_count 10 and color_scale 1.0.
// ----------------------------------------------------------------------------
// lyapunov_exponent_pixel_unit
// Lyapunov exponent of one AB logistic-map pixel on a shared multiplier.
// ----------------------------------------------------------------------------
module lyapunov_exponent_pixel_unit
  import lep_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_a_coord,
  input  logic signed [31:0] in_b_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_pixel_color,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [18:0] {
    S_IDLE    = 19'h1 << 0,
    S_X_MUL   = 19'h1 << 1,
    S_P_ABS   = 19'h1 << 2,
    S_Q_MUL   = 19'h1 << 3,
    S_X_UPD   = 19'h1 << 4,
    S_D_ABS   = 19'h1 << 5,
    S_M_MUL   = 19'h1 << 6,
    S_NORM_LD = 19'h1 << 7,
    S_NORM    = 19'h1 << 8,
    S_TAB     = 19'h1 << 9,
    S_I_MUL   = 19'h1 << 10,
    S_L2      = 19'h1 << 11,
    S_L_MUL   = 19'h1 << 12,
    S_ACC     = 19'h1 << 13,
    S_DIV_LD  = 19'h1 << 14,
    S_DIV     = 19'h1 << 15,
    S_C_MUL   = 19'h1 << 16,
    S_C_WAIT  = 19'h1 << 17,
    S_FIN     = 19'h1 << 18
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  round_count_r;
  logic [31:0] color_scale_r;

  logic signed [31:0] a_r, b_r, x_r;
  logic signed [31:0] sum_r;
  logic [7:0]  round_r;
  logic        step_r;
  logic [31:0] r_mag_r;
  logic        r_neg_r;
  logic [32:0] p_mag_r;
  logic        p_neg_r;
  logic [32:0] d_mag_r;
  logic [63:0] m_r;
  logic [5:0]  k_r;
  logic [2:0]  ncnt_r;
  logic [TAB_W-1:0] lo_r, diff_r;
  logic [REM_W-1:0] rem_r;
  logic signed [33:0] l2_r;
  logic [31:0] quot_r;
  logic        out_valid_r;
  logic [23:0] out_color_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  logic        div_start, div_done;
  logic [31:0] div_quot;
  logic [7:0]  divisor;
  logic [31:0] sum_mag;

  // shared multiplier and divider
  lep_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  lep_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign divisor   = (round_count_r == 8'd0) ? 8'd1 : round_count_r;
  assign sum_mag   = sum_r[31] ? 32'(-{sum_r[31], sum_r}) : 32'(sum_r);
  assign div_start = (state_r == S_DIV_LD);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_X_MUL: begin
        mul_a = MUL_W'(x_r);
        mul_b = ONE_Q30 - MUL_W'(x_r);
      end
      S_Q_MUL: begin
        mul_a = MUL_W'({1'b0, r_mag_r});
        mul_b = MUL_W'({1'b0, p_mag_r});
      end
      S_M_MUL: begin
        mul_a = MUL_W'({1'b0, r_mag_r});
        mul_b = MUL_W'({1'b0, d_mag_r});
      end
      S_I_MUL: begin
        mul_a = MUL_W'({1'b0, diff_r});
        mul_b = MUL_W'({1'b0, rem_r});
      end
      S_L_MUL: begin
        mul_a = MUL_W'(l2_r);
        mul_b = MUL_W'({1'b0, LN2_Q30});
      end
      // color product held until the result register takes it
      S_C_MUL, S_C_WAIT, S_FIN: begin
        mul_a = MUL_W'({1'b0, color_scale_r});
        mul_b = MUL_W'({1'b0, quot_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // step datapath values
  logic signed [35:0] p_full;
  logic [35:0]        q_val;
  logic               x_neg;
  logic signed [31:0] x_nxt;
  logic signed [33:0] d_val;
  logic signed [31:0] r_sel;
  logic [5:0]         sh;
  logic [63:0]        top_mask;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic [TAB_IDX_W-1:0]      idx_lo, idx_hi;
  logic [TAB_W-1:0]   tab_lo, tab_hi, frac;
  logic signed [6:0]  km58;
  logic signed [35:0] ln_val;
  logic signed [36:0] sum_ext;
  logic signed [31:0] sum_nxt;
  logic [31:0]        color_full;
  logic [23:0]        color;
  logic               last_step;

  always_comb begin
    p_full = prod[65:30];
    q_val  = 36'(prod[63:28]);
    x_neg  = r_neg_r ^ p_neg_r;
    if (x_neg) begin
      x_nxt = (q_val > 36'h080000000) ? 32'sh80000000 : 32'(-q_val);
    end else begin
      x_nxt = (q_val > 36'h07FFFFFFF) ? 32'sh7FFFFFFF : 32'(q_val);
    end
    d_val = 34'(64'd1 << 30) - {x_r[31], x_r, 1'b0};
    r_sel = step_r ? b_r : a_r;

    // leading-one search: halving shift amounts
    case (ncnt_r)
      3'd0:    sh = 6'd32;
      3'd1:    sh = 6'd16;
      3'd2:    sh = 6'd8;
      3'd3:    sh = 6'd4;
      3'd4:    sh = 6'd2;
      default: sh = 6'd1;
    endcase
    top_mask = ~({64{1'b1}} >> sh);

    idx    = m_r[62 -: LOG_TABLE_BITS];
    idx_lo = {1'b0, idx};
    idx_hi = idx_lo + TAB_IDX_W'(1);
    tab_lo = LOG_TAB[idx_lo];
    tab_hi = LOG_TAB[idx_hi];
    frac   = lo_r + TAB_W'(prod[TAB_W+REM_W-1:REM_W]);
    km58   = $signed({1'b0, k_r}) - 7'sd58;

    // floor of the Q.24 log, then saturating accumulate
    ln_val  = prod[67:32];
    sum_ext = 37'(sum_r) + 37'(ln_val);
    if (sum_ext > 37'sh007FFFFFFF) begin
      sum_nxt = 32'sh7FFFFFFF;
    end else if (sum_ext < -37'sh0080000000) begin
      sum_nxt = 32'sh80000000;
    end else begin
      sum_nxt = 32'(sum_ext);
    end

    color_full = 32'(prod[71:40]);
    color      = (color_full[31:24] != 8'd0) ? 24'hFFFFFF : color_full[23:0];
    last_step  = step_r && (round_r == round_count_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_X_MUL;
      S_X_MUL:   state_nxt = S_P_ABS;
      S_P_ABS:   state_nxt = S_Q_MUL;
      S_Q_MUL:   state_nxt = S_X_UPD;
      S_X_UPD:   state_nxt = S_D_ABS;
      S_D_ABS:   state_nxt = S_M_MUL;
      S_M_MUL:   state_nxt = S_NORM_LD;
      S_NORM_LD: begin
        if (prod[63:0] != 64'd0) begin
          state_nxt = S_NORM;
        end else begin
          state_nxt = last_step ? S_DIV_LD : S_X_MUL;
        end
      end
      S_NORM:    if (ncnt_r == 3'd5) state_nxt = S_TAB;
      S_TAB:     state_nxt = S_I_MUL;
      S_I_MUL:   state_nxt = S_L2;
      S_L2:      state_nxt = S_L_MUL;
      S_L_MUL:   state_nxt = S_ACC;
      S_ACC:     state_nxt = last_step ? S_DIV_LD : S_X_MUL;
      S_DIV_LD:  state_nxt = S_DIV;
      S_DIV:     if (div_done) state_nxt = S_C_MUL;
      S_C_MUL:   state_nxt = S_C_WAIT;
      S_C_WAIT:  state_nxt = S_FIN;
      S_FIN:     if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      round_count_r <= ROUND_COUNT_RST;
      color_scale_r <= COLOR_SCALE_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_ROUND_COUNT: round_count_r <= cfg_data[7:0];
          REG_COLOR_SCALE: color_scale_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // step advance shared by the zero-derivative skip and the accumulate
  logic advance;
  assign advance = (state_r == S_ACC) ||
                   (state_r == S_NORM_LD && prod[63:0] == 64'd0);

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        a_r     <= in_a_coord;
        b_r     <= in_b_coord;
        x_r     <= 32'sh20000000;
        sum_r   <= '0;
        round_r <= '0;
        step_r  <= 1'b0;
      end
      S_P_ABS: begin
        p_neg_r <= p_full[35];
        p_mag_r <= p_full[35] ? 33'(-p_full) : 33'(p_full);
        r_neg_r <= r_sel[31];
        r_mag_r <= r_sel[31] ? 32'(-{r_sel[31], r_sel}) : 32'(r_sel);
      end
      S_X_UPD: x_r <= x_nxt;
      S_D_ABS: d_mag_r <= d_val[33] ? 33'(-d_val) : 33'(d_val);
      S_NORM_LD: begin
        m_r    <= prod[63:0];
        k_r    <= 6'd63;
        ncnt_r <= '0;
      end
      S_NORM: begin
        ncnt_r <= ncnt_r + 3'd1;
        if ((m_r & top_mask) == 64'd0) begin
          m_r <= m_r << sh;
          k_r <= k_r - sh;
        end
      end
      S_TAB: begin
        lo_r   <= tab_lo;
        diff_r <= tab_hi - tab_lo;
        rem_r  <= m_r[62-LOG_TABLE_BITS -: REM_W];
      end
      S_L2:  l2_r <= {km58[6], km58, 26'd0} + {7'd0, frac};
      S_ACC: sum_r <= sum_nxt;
      S_DIV: if (div_done) quot_r <= div_quot;
      S_FIN: if (!out_valid_r || out_ready) out_color_r <= color;
      default: ;
    endcase
    if (advance) begin
      step_r <= ~step_r;
      if (step_r) round_r <= round_r + 8'd1;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;

endmodule

@@ sv/lep_mul.sv @@
// ----------------------------------------------------------------------------
// lep_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lep_mul
  import lep_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  mul_a,
  input  logic signed [MUL_W-1:0]  mul_b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  // one product per cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod = prod_r;

endmodule

@@ sv/lep_div.sv @@
// ----------------------------------------------------------------------------
// lep_div
// Restoring divider: 32-bit unsigned dividend by 8-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module lep_div
  import lep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [7:0]  rem_r;
  logic [31:0] quo_r;
  logic [8:0]  trial;
  logic        fits;
  logic [7:0]  rem_nxt;

  // trial subtract of the shifted remainder
  always_comb begin
    trial   = {rem_r, quo_r[31]};
    fits    = trial >= {1'b0, divisor};
    rem_nxt = fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[30:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
